// ===== sv/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants for the dendrogram height tracker: field widths, command
// codes and the parameter defaults handed to the top level.
// ----------------------------------------------------------------------------
package dht_pkg;

  // Width of a cluster id on the input ports.
  localparam int ID_W = 10;

  // Defaults for the top-level parameters.
  localparam int CLUSTER_IDS_DEF  = 1024;
  localparam int HEIGHT_WIDTH_DEF = 12;

  // Command codes carried in in_cmd.
  localparam logic CMD_JOIN   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

endpackage

// ===== sv/dht_ram.sv =====
// ----------------------------------------------------------------------------
// dht_ram
// Generic synchronous RAM: one write port and two read ports, read data
// registered. A read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module dht_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first storage array with registered outputs.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== sv/dendrogram_height_tracker.sv =====
// ----------------------------------------------------------------------------
// dendrogram_height_tracker
// Keeps the subtree height of every live cluster while clustering joins
// arrive, and folds all live heights into one dendrogram height on finish.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      in         in_valid / in_stall  in_cmd, in_left_id, in_right_id
//   out_     out        out_valid / out_stall out_tree_height
//
// A join reads the two ids from the store in the beat cycle, writes the
// survivor in the next, and clears the absorbed id in the cycle after that,
// when the next beat can already be taken. A finish sweeps the whole store,
// one entry a cycle, and the sweep clears the store. After reset the same
// sweep clears the store, with in_stall held high throughout. The result sits
// in an output register, so joins keep flowing while out_stall holds it; a
// second finish waits for it.
//
module dendrogram_height_tracker
  import dht_pkg::*;
#(
  parameter int CLUSTER_IDS  = CLUSTER_IDS_DEF,
  parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [ID_W-1:0]         in_left_id,
  input  logic [ID_W-1:0]         in_right_id,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HEIGHT_WIDTH-1:0] out_tree_height
);

  localparam int AW = $clog2(CLUSTER_IDS);
  localparam int CW = AW + 1;
  localparam int MW = HEIGHT_WIDTH + 1;

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_WRJ  = 6'b000100,
    ST_CLR  = 6'b001000,
    ST_SCAN = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // Saturating increment of a height.
  function automatic logic [HEIGHT_WIDTH-1:0] sat_inc(input logic [HEIGHT_WIDTH-1:0] h);
    sat_inc = (h == '1) ? h : h + 1'b1;
  endfunction

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    sweep_vld_r, sweep_vld_nxt;
  logic [HEIGHT_WIDTH-1:0] run_r, run_nxt;
  logic                    seen_r, seen_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [HEIGHT_WIDTH-1:0] out_height_r, out_height_nxt;
  logic                    ki_r, ki_nxt;
  logic                    fwd_a_r, fwd_a_nxt;
  logic                    fwd_b_r, fwd_b_nxt;
  logic [AW-1:0]           li_r, li_nxt;
  logic [AW-1:0]           rj_r, rj_nxt;

  logic                    in_acc;
  logic                    ids_ok;
  logic                    sweep_issue;
  logic [AW-1:0]           in_li_addr;
  logic [AW-1:0]           in_rj_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [MW-1:0]           wr_data;
  logic [AW-1:0]           rd_addr_a;
  logic [MW-1:0]           rd_data_a;
  logic [MW-1:0]           rd_data_b;
  logic                    ki, kj;
  logic [HEIGHT_WIDTH-1:0] hi, hj, h_new, fold_max;

  // Beat acceptance and id decoding.
  assign in_stall   = !(state_r == ST_IDLE || state_r == ST_CLR);
  assign in_acc     = in_valid && !in_stall;
  assign in_li_addr = AW'(in_left_id);
  assign in_rj_addr = AW'(in_right_id);
  assign ids_ok     = (32'(in_left_id) < 32'(CLUSTER_IDS)) &&
                      (32'(in_right_id) < 32'(CLUSTER_IDS));
  assign sweep_issue = (state_r == ST_INIT || state_r == ST_SCAN) &&
                       (cnt_r != CW'(CLUSTER_IDS));

  // Store word: live mark on top, height below.
  assign rd_addr_a = sweep_issue ? cnt_r[AW-1:0] : in_li_addr;

  dht_ram #(
    .WIDTH (MW),
    .DEPTH (CLUSTER_IDS)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (in_rj_addr),
    .rd_data_b (rd_data_b)
  );

  // Join arithmetic; a clear written in the beat cycle is forwarded.
  assign ki    = rd_data_a[MW-1] && !fwd_a_r;
  assign kj    = rd_data_b[MW-1] && !fwd_b_r;
  assign hi    = rd_data_a[HEIGHT_WIDTH-1:0];
  assign hj    = rd_data_b[HEIGHT_WIDTH-1:0];

  always_comb begin
    if (ki && kj) begin
      h_new = sat_inc((hi > hj) ? hi : hj);
    end else if (ki) begin
      h_new = sat_inc(hi);
    end else if (kj) begin
      h_new = sat_inc(hj);
    end else begin
      h_new = HEIGHT_WIDTH'(1);
    end
  end

  assign fold_max = (run_r > hi) ? run_r : hi;

  // Write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = '0;
    if (sweep_issue) begin
      wr_en = 1'b1;
    end else if (state_r == ST_WRJ) begin
      wr_en   = 1'b1;
      wr_addr = rj_r;
      wr_data = {1'b1, h_new};
    end else if (state_r == ST_CLR) begin
      wr_en   = ki_r;
      wr_addr = li_r;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sweep_vld_nxt  = sweep_issue;
    run_nxt        = run_r;
    seen_nxt       = seen_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_height_nxt = out_height_r;
    ki_nxt         = ki_r;
    fwd_a_nxt      = 1'b0;
    fwd_b_nxt      = 1'b0;
    li_nxt         = li_r;
    rj_nxt         = rj_r;

    if (sweep_issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      ST_INIT: begin
        if (!sweep_issue && !sweep_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE, ST_CLR: begin
        if (in_acc) begin
          if (in_cmd == CMD_FINISH) begin
            state_nxt = ST_SCAN;
            cnt_nxt   = '0;
            run_nxt   = '0;
            seen_nxt  = 1'b0;
          end else if (ids_ok) begin
            state_nxt = ST_WRJ;
            li_nxt    = in_li_addr;
            rj_nxt    = in_rj_addr;
            fwd_a_nxt = (state_r == ST_CLR) && ki_r && (in_li_addr == li_r);
            fwd_b_nxt = (state_r == ST_CLR) && ki_r && (in_rj_addr == li_r);
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WRJ: begin
        ki_nxt    = ki;
        state_nxt = ST_CLR;
      end
      ST_SCAN: begin
        // Fold the entry read in the previous cycle.
        if (sweep_vld_r && rd_data_a[MW-1]) begin
          seen_nxt = 1'b1;
          run_nxt  = seen_r ? sat_inc(fold_max) : hi;
        end
        if (!sweep_issue && !sweep_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_height_nxt = run_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      sweep_vld_r <= 1'b0;
      run_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ki_r        <= 1'b0;
      fwd_a_r     <= 1'b0;
      fwd_b_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sweep_vld_r <= sweep_vld_nxt;
      run_r       <= run_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      ki_r        <= ki_nxt;
      fwd_a_r     <= fwd_a_nxt;
      fwd_b_r     <= fwd_b_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_height_r <= out_height_nxt;
    li_r         <= li_nxt;
    rj_r         <= rj_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tree_height = out_height_r;

  // A join with ids in range always proceeds to the survivor write.
  a_join_to_wrj: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_cmd == CMD_JOIN) && ids_ok |=> state_r == ST_WRJ)
    else $error("join beat did not reach the survivor write");

  // A finish beat blocks the input until the sweep is over.
  a_finish_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_cmd == CMD_FINISH) |=> in_stall)
    else $error("input taken right after a finish beat");

  // The sweep counter never runs past the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CLUSTER_IDS))
    else $error("sweep counter out of range");

  // A new result is loaded only when the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid_r && out_stall |=> state_r == ST_DONE)
    else $error("result overwritten while stalled");

endmodule
